[rtl/core/dqm_pkg.sv]
// Shared types and fixed field widths for the deque with match count and purge.
package dqm_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_COUNT      = 3'd4,
    CMD_PURGE      = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_LOAD
  } state_t;

endpackage

[rtl/core/dqm_ram.sv]
// Entry storage: one write port and two registered read ports.
module dqm_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/core/deque_with_match_count_and_purge_unit.sv]
// Bounded double-ended queue with match counting and purge, top level.
//
// Commands arrive on the cmd channel (command, item_value) and each one yields
// exactly one transaction on the rsp channel that describes the queue after it.
// Entries live in a ring memory addressed from a head pointer, so a push takes
// one write and a pop none at either end, with no data movement.
// Push, pop and unused codes pass from acceptance through S_FETCH and S_LOAD
// to the output register. Count and purge on a non-empty queue first walk the
// stored entries in S_SCAN through one comparator, one entry read per cycle
// with the purge write-back overlapped, then pass through S_FETCH and S_LOAD.
// The next command can be accepted the cycle after its result is loaded.
// The cmd channel stalls while a command is in work, so one command is in
// flight at a time. A finished result waits in the output register; the next
// command is accepted meanwhile and holds in its last cycle until the
// receiver takes the waiting result.
// Reset empties the queue at once; the memory contents are not cleared and
// are never read before being written.
module deque_with_match_count_and_purge_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [dqm_pkg::CMD_W-1:0]     command,
  input  logic [dqm_pkg::DATA_W-1:0]    item_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [dqm_pkg::STATUS_W-1:0]  status,
  output logic [dqm_pkg::FILL_W-1:0]    match_count,
  output logic [dqm_pkg::FILL_W-1:0]    fill_level,
  output logic [dqm_pkg::DATA_W-1:0]    front_item,
  output logic [dqm_pkg::DATA_W-1:0]    back_item,
  output logic                          is_empty
);

  import dqm_pkg::*;

  localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

  state_t                state, state_next;
  logic [PTR_W-1:0]      head, head_next;
  logic [CNT_W-1:0]      count, count_next;
  cmd_t                  cmd_r, cmd_r_next;
  logic [ITEM_WIDTH-1:0] val_r, val_r_next;
  stat_t                 pstat, pstat_next;
  logic [CNT_W-1:0]      scan_idx, scan_idx_next;
  logic                  pend, pend_next;
  logic [CNT_W-1:0]      kept, kept_next;
  logic [CNT_W-1:0]      matched, matched_next;
  logic                  load;

  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic [PTR_W-1:0]      rd_addr_a, rd_addr_b;
  logic [ITEM_WIDTH-1:0] rd_data_a, rd_data_b;
  logic [ITEM_WIDTH-1:0] val_in;
  logic                  full, empty;

  assign val_in    = ITEM_WIDTH'(item_value);
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign cmd_stall = (state != S_IDLE);
  assign rd_addr_a = (state == S_SCAN) ? ring_add(head, scan_idx) : head;
  assign rd_addr_b = ring_add(head, empty ? CNT_W'(0) : count - CNT_W'(1));

  dqm_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ITEM_WIDTH),
    .AW   (PTR_W)
  ) u_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .raddr_a(rd_addr_a),
    .raddr_b(rd_addr_b),
    .rdata_a(rd_data_a),
    .rdata_b(rd_data_b)
  );

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    cmd_r_next    = cmd_r;
    val_r_next    = val_r;
    pstat_next    = pstat;
    scan_idx_next = scan_idx;
    pend_next     = 1'b0;
    kept_next     = kept;
    matched_next  = matched;
    load          = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = head;
    wr_data       = val_in;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_r_next    = cmd_t'(command);
          val_r_next    = val_in;
          pstat_next    = STAT_OK;
          scan_idx_next = '0;
          kept_next     = '0;
          matched_next  = '0;
          state_next    = S_FETCH;
          unique case (cmd_t'(command))
            CMD_PUSH_FRONT: begin
              if (full) begin
                pstat_next = STAT_FULL;
              end else begin
                head_next  = (head == '0) ? PTR_W'(CAPACITY - 1) : head - PTR_W'(1);
                wr_en      = 1'b1;
                wr_addr    = head_next;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                pstat_next = STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(head, count);
                count_next = count + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                pstat_next = STAT_EMPTY;
              end else begin
                head_next  = ring_add(head, CNT_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                pstat_next = STAT_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
            CMD_COUNT, CMD_PURGE: begin
              if (!empty) begin
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_idx != count) begin
          scan_idx_next = scan_idx + CNT_W'(1);
          pend_next     = 1'b1;
        end
        if (pend) begin
          if (rd_data_a == val_r) begin
            matched_next = matched + CNT_W'(1);
          end else if (cmd_r == CMD_PURGE) begin
            wr_en     = 1'b1;
            wr_addr   = ring_add(head, kept);
            wr_data   = rd_data_a;
            kept_next = kept + CNT_W'(1);
          end
        end
        if (scan_idx == count && !pend) begin
          if (cmd_r == CMD_PURGE) begin
            count_next = kept;
          end
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!rsp_valid || !rsp_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    val_r    <= val_r_next;
    pstat    <= pstat_next;
    scan_idx <= scan_idx_next;
    kept     <= kept_next;
    matched  <= matched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= pstat;
      match_count <= FILL_W'(matched);
      fill_level  <= FILL_W'(count);
      front_item  <= empty ? '0 : DATA_W'(rd_data_a);
      back_item   <= empty ? '0 : DATA_W'(rd_data_b);
      is_empty    <= empty;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_purge_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (kept <= scan_idx))
    else $error("purge write-back overtook the read pointer");

  a_empty_items: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_empty) |-> (front_item == '0 && back_item == '0))
    else $error("empty queue reports nonzero end items");

  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state == S_FETCH || state == S_SCAN))
    else $error("accepted command did not start work");
`endif

endmodule

[dv/deque_with_match_count_and_purge_checker.sv]
// Checker that mirrors the deque contents and compares every result transaction.
module deque_with_match_count_and_purge_checker #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic [dqm_pkg::CMD_W-1:0]    command,
  input  logic [dqm_pkg::DATA_W-1:0]   item_value,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  logic [dqm_pkg::STATUS_W-1:0] status,
  input  logic [dqm_pkg::FILL_W-1:0]   match_count,
  input  logic [dqm_pkg::FILL_W-1:0]   fill_level,
  input  logic [dqm_pkg::DATA_W-1:0]   front_item,
  input  logic [dqm_pkg::DATA_W-1:0]   back_item,
  input  logic                         is_empty,
  output int                           fail_count,
  output int                           pending_results,
  output int                           checked_results,
  output int                           full_refusals,
  output int                           empty_refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  import dqm_pkg::*;

  typedef struct packed {
    stat_t             status;
    logic [FILL_W-1:0] match_count;
    logic [FILL_W-1:0] fill_level;
    logic [DATA_W-1:0] front_item;
    logic [DATA_W-1:0] back_item;
    logic              is_empty;
  } deque_result_t;

  logic [ITEM_WIDTH-1:0] mirror_entries[$];
  deque_result_t         awaited_results[$];
  int                    mismatches = 0;
  int                    compared = 0;
  int                    full_seen = 0;
  int                    empty_seen = 0;

  function automatic deque_result_t apply_command(input logic [CMD_W-1:0] op,
                                                  input logic [DATA_W-1:0] value);
    deque_result_t         r;
    logic [ITEM_WIDTH-1:0] target;
    logic [ITEM_WIDTH-1:0] kept[$];
    int                    hits;
    target   = value[ITEM_WIDTH-1:0];
    hits     = 0;
    r.status = STAT_OK;
    case (op)
      CMD_PUSH_FRONT: begin
        if (mirror_entries.size() >= CAPACITY) r.status = STAT_FULL;
        else mirror_entries.push_front(target);
      end
      CMD_PUSH_BACK: begin
        if (mirror_entries.size() >= CAPACITY) r.status = STAT_FULL;
        else mirror_entries.push_back(target);
      end
      CMD_POP_FRONT: begin
        if (mirror_entries.size() == 0) r.status = STAT_EMPTY;
        else void'(mirror_entries.pop_front());
      end
      CMD_POP_BACK: begin
        if (mirror_entries.size() == 0) r.status = STAT_EMPTY;
        else void'(mirror_entries.pop_back());
      end
      CMD_COUNT: begin
        foreach (mirror_entries[i]) if (mirror_entries[i] == target) hits++;
      end
      CMD_PURGE: begin
        foreach (mirror_entries[i]) begin
          if (mirror_entries[i] == target) hits++;
          else kept.push_back(mirror_entries[i]);
        end
        mirror_entries = kept;
      end
      default: ;
    endcase
    r.match_count = hits[FILL_W-1:0];
    r.fill_level  = FILL_W'(mirror_entries.size());
    r.is_empty    = (mirror_entries.size() == 0);
    r.front_item  = r.is_empty ? '0 : DATA_W'(mirror_entries[0]);
    r.back_item   = r.is_empty ? '0 : DATA_W'(mirror_entries[mirror_entries.size() - 1]);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          $error("Result transaction arrived with no command waiting for it.");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", DATA_W'(want.status), DATA_W'(status));
          compare_field("match_count", DATA_W'(want.match_count), DATA_W'(match_count));
          compare_field("fill_level", DATA_W'(want.fill_level), DATA_W'(fill_level));
          compare_field("front_item", want.front_item, front_item);
          compare_field("back_item", want.back_item, back_item);
          compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty));
          compared++;
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want = apply_command(command, item_value);
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_EMPTY) empty_seen++;
        awaited_results.push_back(want);
      end
    end
    fail_count      <= mismatches;
    pending_results <= awaited_results.size();
    checked_results <= compared;
    full_refusals   <= full_seen;
    empty_refusals  <= empty_seen;
  end

endmodule

[dv/deque_with_match_count_and_purge_unit_test.sv]
// Top-level testbench that drives commands into the deque and reports the verdict.
module deque_with_match_count_and_purge_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqm_pkg::*;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned ITEM_WIDTH    = 32;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          DRAIN_CYCLES  = 30;
  localparam int          RANDOM_BLOCKS = 20;
  localparam int          BLOCK_ITEMS   = 50;
  localparam int          CALM_BLOCK    = 5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic [CMD_W-1:0]    command = '0;
  logic [DATA_W-1:0]   item_value = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   match_count;
  logic [FILL_W-1:0]   fill_level;
  logic [DATA_W-1:0]   front_item;
  logic [DATA_W-1:0]   back_item;
  logic                is_empty;

  int fail_count;
  int pending_results;
  int checked_results;
  int full_refusals;
  int empty_refusals;

  int cmd_idle_pct = 23;
  int rsp_idle_pct = 23;
  int hold_requests = 0;
  int sent_by_op[8];

  logic [DATA_W-1:0] value_pool[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                                       32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000};

  always #5 clk = ~clk;

  deque_with_match_count_and_purge_unit #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .item_value (item_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .match_count(match_count),
    .fill_level (fill_level),
    .front_item (front_item),
    .back_item  (back_item),
    .is_empty   (is_empty)
  );

  deque_with_match_count_and_purge_checker #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) result_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .command        (command),
    .item_value     (item_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .match_count    (match_count),
    .fill_level     (fill_level),
    .front_item     (front_item),
    .back_item      (back_item),
    .is_empty       (is_empty),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .checked_results(checked_results),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  task automatic send_command(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < cmd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    command    <= op;
    item_value <= value;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent_by_op[op]++;
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    if (r < 97) return $urandom_range(1) ? CMD_PURGE : CMD_COUNT;
    return $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom();
    return value_pool[$urandom_range(5)];
  endfunction

  initial begin : receiver
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timed out after %0d cycles with no transaction.", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int push_pct;
    int pop_pct;
    int total;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_command(CMD_COUNT, 32'h0);
    send_command(CMD_PURGE, 32'hFFFF_FFFF);
    send_command(CMD_UNUSED_LO, 32'h1234_5678);
    for (int i = 0; i < CAPACITY; i++) begin
      send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, value_pool[i % 6]);
    end
    send_command(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_command(CMD_COUNT, 32'hFFFF_FFFF);
    send_command(CMD_PURGE, 32'h0000_0000);
    send_command(CMD_UNUSED_HI, 32'hFFFF_FFFF);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);

    hold_requests++;
    repeat (40) send_command(pick_command(50, 20), pick_value());

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case ($urandom_range(2))
        0: begin push_pct = 60; pop_pct = 20; end
        1: begin push_pct = 20; pop_pct = 60; end
        default: begin push_pct = 40; pop_pct = 40; end
      endcase
      cmd_idle_pct = (blk == CALM_BLOCK) ? 0 : 23;
      rsp_idle_pct = (blk == CALM_BLOCK) ? 0 : 23;
      repeat (BLOCK_ITEMS) send_command(pick_command(push_pct, pop_pct), pick_value());
    end
    cmd_valid <= 1'b0;

    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    total = 0;
    foreach (sent_by_op[i]) total += sent_by_op[i];
    $display("Covered %0d commands: %0d/%0d push front/back, %0d/%0d pop front/back,",
             total, sent_by_op[CMD_PUSH_FRONT], sent_by_op[CMD_PUSH_BACK],
             sent_by_op[CMD_POP_FRONT], sent_by_op[CMD_POP_BACK]);
    $display("%0d count, %0d purge, %0d unused; %0d results checked, %0d full, %0d empty refusals.",
             sent_by_op[CMD_COUNT], sent_by_op[CMD_PURGE],
             sent_by_op[CMD_UNUSED_LO] + sent_by_op[CMD_UNUSED_HI],
             checked_results, full_refusals, empty_refusals);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
